FILE: hw/rtl/sm3_pkg.sv
// Shared types, constants and round functions for the SM3 hash engine.
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } sm3_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } sm3_rsp_type;

   localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
   localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [255:0] SM3_IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

   // Rotate left by a value known only at run time.
   function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
   endfunction

   // Control handed from the front end to the compression core.
   typedef struct packed {
      logic start;
      logic busy;
   } sm3_core_ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sm3_hash_engine.sv
// Top level of the SM3 hash engine: byte packing, padding and digest output.
// Usage:
// The req_ channel carries one word per handshake: an optional message
// byte (byte_valid) and a last marker. Bytes pack big-endian into 64-byte
// blocks. A byte that does not fill a block is taken without a stall. The
// sixty-fourth byte starts a compression (a load, 64 rounds in the shared
// round unit, then a fold into the chaining value), during which
// req_stall is high. A last marker pads the message and runs one or two
// more compressions, then the eight digest words leave on the rsp_ channel,
// word_index 0 first, last_word set on the eighth. A rsp_stall holds the
// current word in the output register; no new item is taken until all
// eight words have gone. After the digest the chaining value returns to the
// initial value and the byte count to zero.
// Reset is synchronous and active high; it restores the initial value, clears
// the byte count and empties the output register. The block buffer is not
// cleared, since padding writes every position not filled by the message.
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine
   import sm3_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sm3_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output sm3_rsp_type      rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COMP  = 6'b000010,
      ST_PAD   = 6'b000100,
      ST_PAD2  = 6'b001000,
      ST_FINAL = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [60:0] count_ff, count_in;
   logic [255:0] cv_ff, cv_in;
   logic pend_last_ff, pend_last_in;
   logic [2:0] widx_ff, widx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic started_ff, started_in;
   sm3_core_ctl_type ctl;
   logic core_busy;
   logic [511:0] blk;
   logic [255:0] cv_new;
   logic accept, fire;
   logic [5:0] pos;
   logic [4:0] lane;
   logic [63:0] bits;

   sm3_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .block_in(blk),
      .cv_in(cv_ff), .busy(core_busy), .cv_out(cv_new));

   // The buffer holds the block as sixteen big-endian words.
   always_comb begin
      for (int i = 0; i < 16; i++) blk[511 - 32 * i -: 32] = buf_ff[i];
   end

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fire = rsp_valid_ff && !rsp_stall;
   assign pos = count_ff[5:0];
   assign lane = {~pos[1:0], 3'b000};
   assign bits = {count_ff, 3'b000};

   // Main sequencer: fill, pad, compress and stream out the digest.
   always_comb begin
      state_in = state_ff;
      buf_in = buf_ff;
      count_in = count_ff;
      cv_in = cv_ff;
      pend_last_in = pend_last_ff;
      widx_in = widx_ff;
      rsp_valid_in = rsp_valid_ff;
      started_in = 1'b0;
      ctl.start = 1'b0;
      ctl.busy = core_busy;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_last_in = req_data.last;
               if (req_data.byte_valid) begin
                  buf_in[pos[5:2]][lane +: 8] = req_data.data_byte;
                  count_in = count_ff + 61'd1;
                  if (pos == 6'd63) begin
                     started_in = 1'b1;
                     state_in = ST_COMP;
                  end else if (req_data.last) begin
                     state_in = ST_PAD;
                  end
               end else if (req_data.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            ctl.start = started_ff;
            if (!started_ff && !core_busy) begin
               cv_in = cv_new;
               state_in = pend_last_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            buf_in[pos[5:2]][lane +: 8] = PAD_BYTE;
            for (int w = 0; w < 16; w++)
               for (int b = 0; b < 4; b++)
                  if (4 * w + b > pos) buf_in[w][31 - 8 * b -: 8] = 8'h00;
            if (pos > 6'd55) begin
               started_in = 1'b1;
               state_in = ST_PAD2;
            end else begin
               buf_in[14] = bits[63:32];
               buf_in[15] = bits[31:0];
               started_in = 1'b1;
               state_in = ST_FINAL;
            end
         end
         ST_PAD2: begin
            ctl.start = started_ff;
            if (!started_ff && !core_busy) begin
               cv_in = cv_new;
               for (int k = 0; k < 14; k++) buf_in[k] = 32'h0;
               buf_in[14] = bits[63:32];
               buf_in[15] = bits[31:0];
               started_in = 1'b1;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            ctl.start = started_ff;
            if (!started_ff && !core_busy) begin
               cv_in = cv_new;
               widx_in = 3'd0;
               rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (fire) begin
               if (widx_ff == 3'd7) begin
                  rsp_valid_in = 1'b0;
                  cv_in = SM3_IV;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  widx_in = widx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      widx_ff <= widx_in;
      pend_last_ff <= pend_last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cv_ff <= SM3_IV;
         rsp_valid_ff <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cv_ff <= cv_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff <= started_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.digest_word = cv_ff[255 - 32 * widx_ff -: 32];
   assign rsp_data.word_index = widx_ff;
   assign rsp_data.last_word = (widx_ff == 3'd7);

   // Results appear only in the output state.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT) else $error("rsp outside output");
   // No input is taken while the round unit works.
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      core_busy |-> req_stall) else $error("accept while busy");
   // The digest closes with the byte count cleared.
   a_count_clr: assert property (@(posedge clock) disable iff (reset)
      fire && widx_ff == 3'd7 |=> count_ff == '0) else $error("count kept");

endmodule
`default_nettype wire

FILE: hw/rtl/sm3_round.sv
// SM3 compression core: one round per cycle over a rolling schedule window.
`timescale 1ns / 1ps
`default_nettype none
module sm3_round
   import sm3_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sm3_core_ctl_type ctl,
   input  wire logic [511:0]     block_in,
   input  wire logic [255:0]     cv_in,
   output logic                  busy,
   output logic [255:0]          cv_out
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [255:0] cv_ff, cv_in_n;
   logic [5:0] j_ff, j_in;
   logic run_ff, run_in;
   logic [31:0] a12, ss1, ss2, tt1, tt2, tj, t, wnew, wj, wj4, ff, gg;

   // One round of expansion and compression from the window head.
   always_comb begin
      tj   = (j_ff < 6'd16) ? TJ_LOW : TJ_HIGH;
      t    = w_ff[0] ^ w_ff[7] ^ {w_ff[13][16:0], w_ff[13][31:17]};
      wnew = perm1(t) ^ {w_ff[3][24:0], w_ff[3][31:25]} ^ w_ff[10];
      wj   = w_ff[0];
      wj4  = w_ff[4];
      a12  = {v_ff[0][19:0], v_ff[0][31:20]};
      ss1  = rol(a12 + v_ff[4] + rol(tj, j_ff[4:0]), 5'd7);
      ss2  = ss1 ^ a12;
      if (j_ff < 6'd16) begin
         ff = v_ff[0] ^ v_ff[1] ^ v_ff[2];
         gg = v_ff[4] ^ v_ff[5] ^ v_ff[6];
      end else begin
         ff = (v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]);
         gg = (v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]);
      end
      tt1 = ff + v_ff[3] + ss2 + (wj ^ wj4);
      tt2 = gg + v_ff[7] + ss1 + wj;
   end

   // Sequencer: load the block and chaining value, then step 64 rounds.
   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      cv_in_n = cv_ff;
      j_in = j_ff;
      run_in = run_ff;
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block_in[511 - 32 * i -: 32];
         for (int i = 0; i < 8; i++) v_in[i] = cv_in[255 - 32 * i -: 32];
         cv_in_n = cv_in;
         j_in = 6'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = wnew;
         v_in[0] = tt1;
         v_in[1] = v_ff[0];
         v_in[2] = {v_ff[1][22:0], v_ff[1][31:23]};
         v_in[3] = v_ff[2];
         v_in[4] = perm0(tt2);
         v_in[5] = v_ff[4];
         v_in[6] = {v_ff[5][12:0], v_ff[5][31:13]};
         v_in[7] = v_ff[6];
         j_in = j_ff + 6'd1;
         if (j_ff == 6'd63) run_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      cv_ff <= cv_in_n;
      j_ff <= j_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign busy = run_ff;

   // Final feed-forward of the working variables.
   always_comb begin
      for (int i = 0; i < 8; i++)
         cv_out[255 - 32 * i -: 32] = cv_ff[255 - 32 * i -: 32] ^ v_ff[i];
   end

endmodule
`default_nettype wire
